/* src/aesdec_pkg.sv */
// Shared types, constants and round functions of the AES-128 decrypt block.
package aesdec_pkg;

  localparam int ROUNDS   = 10;
  localparam int NUM_KEYS = ROUNDS + 1;
  localparam int KEY_AW   = $clog2(NUM_KEYS);
  localparam int BLK_W    = 128;
  localparam int HALF_W   = 64;
  localparam int IDX_W    = 4;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRST,
    OP_MID,
    OP_LAST
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic              key_wr;
    logic [KEY_AW-1:0] rd_addr;
  } dp_cmd_t;

  localparam logic [7:0] RSUB_LUT [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // InvMixColumns as a premultiply by (4x^2+5) followed by MixColumns.
  function automatic logic [BLK_W-1:0] inv_mix(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    logic [7:0] b0, b1, b2, b3, u, v, t;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      b0 = s[BLK_W-1-8*(4*c)   -: 8];
      b1 = s[BLK_W-1-8*(4*c+1) -: 8];
      b2 = s[BLK_W-1-8*(4*c+2) -: 8];
      b3 = s[BLK_W-1-8*(4*c+3) -: 8];
      u  = xtime(xtime(b0 ^ b2));
      v  = xtime(xtime(b1 ^ b3));
      b0 = b0 ^ u;
      b1 = b1 ^ v;
      b2 = b2 ^ u;
      b3 = b3 ^ v;
      t  = b0 ^ b1 ^ b2 ^ b3;
      r[BLK_W-1-8*(4*c)   -: 8] = b0 ^ t ^ xtime(b0 ^ b1);
      r[BLK_W-1-8*(4*c+1) -: 8] = b1 ^ t ^ xtime(b1 ^ b2);
      r[BLK_W-1-8*(4*c+2) -: 8] = b2 ^ t ^ xtime(b2 ^ b3);
      r[BLK_W-1-8*(4*c+3) -: 8] = b3 ^ t ^ xtime(b3 ^ b0);
    end
    return r;
  endfunction

  // InvShiftRows then InvSubBytes; byte r+4c moves to column c+r.
  function automatic logic [BLK_W-1:0] inv_rows_bytes(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] t;
    logic [BLK_W-1:0] r;
    t = '0;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        t[BLK_W-1-8*(w+4*((c+w)%4)) -: 8] = s[BLK_W-1-8*(w+4*c) -: 8];
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[BLK_W-1-8*i -: 8] = RSUB_LUT[t[BLK_W-1-8*i -: 8]];
    end
    return r;
  endfunction

endpackage

/* src/aesdec_req_if.sv */
// Request channel: round key loads and ciphertext blocks.
interface aesdec_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  round_index;
  logic [63:0] data_hi;
  logic [63:0] data_lo;

  modport source (output valid, req_type, round_index, data_hi, data_lo, input ready);
  modport sink   (input valid, req_type, round_index, data_hi, data_lo, output ready);
endinterface

/* src/aesdec_rsp_if.sv */
// Response channel: plaintext blocks.
interface aesdec_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_hi;
  logic [63:0] plain_lo;

  modport source (output valid, plain_hi, plain_lo, input ready);
  modport sink   (input valid, plain_hi, plain_lo, output ready);
endinterface

/* src/aesdec_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module aesdec_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* src/aesdec_dp.sv */
// Datapath: round key store, state register, shared round unit, result register.
module aesdec_dp (
  input  logic                          clk,
  input  aesdec_pkg::dp_cmd_t           cmd,
  input  logic [aesdec_pkg::IDX_W-1:0]  round_index,
  input  logic [aesdec_pkg::HALF_W-1:0] data_hi,
  input  logic [aesdec_pkg::HALF_W-1:0] data_lo,
  output logic [aesdec_pkg::HALF_W-1:0] plain_hi,
  output logic [aesdec_pkg::HALF_W-1:0] plain_lo
);
  import aesdec_pkg::*;

  logic [BLK_W-1:0] blk;
  logic [BLK_W-1:0] plain;
  logic [BLK_W-1:0] key;
  logic [BLK_W-1:0] mixed;

  aesdec_ram #(
    .WIDTH(BLK_W),
    .DEPTH(NUM_KEYS)
  ) u_key_ram (
    .clk    (clk),
    .wr_en  (cmd.key_wr),
    .wr_addr(round_index[KEY_AW-1:0]),
    .wr_data({data_hi, data_lo}),
    .rd_addr(cmd.rd_addr),
    .rd_data(key)
  );

  assign mixed = inv_mix(blk ^ key);

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:  blk   <= {data_hi, data_lo};
      OP_FIRST: blk   <= inv_rows_bytes(blk ^ key);
      OP_MID:   blk   <= inv_rows_bytes(mixed);
      OP_LAST:  plain <= blk ^ key;
      default: ;
    endcase
  end

  assign plain_hi = plain[BLK_W-1:HALF_W];
  assign plain_lo = plain[HALF_W-1:0];

endmodule

/* src/aesdec_ctrl.sv */
// Controller: request decode, round sequencing and response valid.
module aesdec_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  input  logic                         req_type,
  input  logic [aesdec_pkg::IDX_W-1:0] round_index,
  output logic                         req_ready,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output aesdec_pkg::dp_cmd_t          cmd
);
  import aesdec_pkg::*;

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t            state;
  logic [KEY_AW-1:0] rnd;       // key index presented on the key RAM output
  logic              req_acc;
  logic              last_go;

  assign req_ready = (state == IDLE);
  assign req_acc   = req_valid && req_ready;
  // final key add waits for the result register to be free
  assign last_go   = (state == RUN) && (rnd == '0) && (!rsp_valid || rsp_ready);

  always_comb begin
    cmd.op      = OP_NONE;
    cmd.key_wr  = req_acc && (req_type == REQ_LOAD) &&
                  (round_index <= IDX_W'(ROUNDS));
    cmd.rd_addr = KEY_AW'(ROUNDS);
    if (req_acc && (req_type == REQ_DECRYPT)) begin
      cmd.op = OP_LOAD;
    end
    if (state == RUN) begin
      if (rnd == '0) begin
        cmd.rd_addr = '0;
        if (last_go) begin
          cmd.op = OP_LAST;
        end
      end else begin
        cmd.rd_addr = rnd - KEY_AW'(1);
        cmd.op      = (rnd == KEY_AW'(ROUNDS)) ? OP_FIRST : OP_MID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rnd       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_acc && (req_type == REQ_DECRYPT)) begin
            state <= RUN;
            rnd   <= KEY_AW'(ROUNDS);
          end
        end
        RUN: begin
          if (rnd != '0) begin
            rnd <= rnd - KEY_AW'(1);
          end else if (last_go) begin
            state     <= IDLE;
            rsp_valid <= 1'b1;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    rnd <= KEY_AW'(ROUNDS))
    else $error("round counter out of range");

  a_start: assert property (@(posedge clk) disable iff (rst)
    (req_acc && req_type == REQ_DECRYPT) |=> (state == RUN && rnd == KEY_AW'(ROUNDS)))
    else $error("decrypt transaction did not start the round sequence");

  a_last_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LAST) |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten while still pending");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LAST) |=> (rsp_valid && state == IDLE))
    else $error("final round did not present a result");

  a_wr_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.key_wr |-> (state == IDLE && cmd.op == OP_NONE))
    else $error("key store written during a block");

endmodule

/* src/aes128_block_decrypt.sv */
// AES-128 inverse cipher: top level joining controller and datapath.
//
// req channel: req_type 0 writes round key round_index (0 to 10) from
// data_hi/data_lo into the key store and gives no response; indexes above
// 10 are dropped. req_type 1 decrypts the ciphertext block in
// data_hi/data_lo. All eleven round keys must be loaded before a decrypt.
// rsp channel: one plaintext block per decrypt transaction, byte 0 in the
// top bits of plain_hi.
// Key loads are taken one per cycle while no decrypt is running. A decrypt
// runs one round per cycle through a single shared round unit, with the key
// store's registered read fetching each round key in the cycle before its
// round: the response becomes valid as the controller returns to idle, and
// only then is the next request taken, so a block waits for the last one.
// The result register frees the round unit: a new request is taken while a
// response still waits. If a result is still unread when the next block
// reaches its final key add, that block holds there until the receiver
// takes the pending response.
// Reset (rst, synchronous) clears the controller and the response valid;
// the key store keeps its contents and is undefined until loaded.
module aes128_block_decrypt (
  input logic         clk,
  input logic         rst,
  aesdec_req_if.sink  req,
  aesdec_rsp_if.source rsp
);
  import aesdec_pkg::*;

  dp_cmd_t cmd;

  aesdec_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_type   (req.req_type),
    .round_index(req.round_index),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .cmd        (cmd)
  );

  aesdec_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .round_index(req.round_index),
    .data_hi    (req.data_hi),
    .data_lo    (req.data_lo),
    .plain_hi   (rsp.plain_hi),
    .plain_lo   (rsp.plain_lo)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the AES-128 decrypt block with a built-in predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aesdec_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1080;

  typedef struct {
    logic        req_type;
    logic [3:0]  round_index;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    bit          drain;
  } key_or_block_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } plain_t;

  logic clk;
  logic rst;

  aesdec_req_if req_ch();
  aesdec_rsp_if rsp_ch();

  aes128_block_decrypt u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state: own S-box tables and own copy of the round key store
  logic [7:0]   fwd_sbox     [256];
  logic [7:0]   rev_sub_lut  [256];
  logic [127:0] round_keys   [ROUNDS+1];

  key_or_block_t pending_reqs[$];
  plain_t        expected_plain[$];
  key_or_block_t in_flight;
  bit            drain_next;
  int            error_count;
  int            results_seen;
  int            req_gap, req_calm;
  int            rsp_gap, rsp_calm;
  int            hold_left;
  bit            long_hold_done;
  int            quiet_cycles;

  always #5 clk = ~clk;

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  // byte row+4*col moves to column col+row, then inverse substitution
  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int col = 0; col < 4; col++) begin
      for (int row = 0; row < 4; row++) begin
        t[127-8*(row+4*((col+row)%4)) -: 8] = rev_sub_lut[s[127-8*(row+4*col) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] decipher_block(input logic [127:0] ct);
    logic [127:0] v;
    logic [7:0]   a0, a1, a2, a3;
    v = unshift_unsub(ct ^ round_keys[ROUNDS]);
    for (int k = ROUNDS - 1; k >= 1; k--) begin
      v = v ^ round_keys[k];
      for (int c = 0; c < 4; c++) begin
        a0 = v[127-32*c -: 8];
        a1 = v[119-32*c -: 8];
        a2 = v[111-32*c -: 8];
        a3 = v[103-32*c -: 8];
        v[127-32*c -: 8] = gf_times(a0, 8'd14) ^ gf_times(a1, 8'd11) ^
                           gf_times(a2, 8'd13) ^ gf_times(a3, 8'd9);
        v[119-32*c -: 8] = gf_times(a0, 8'd9) ^ gf_times(a1, 8'd14) ^
                           gf_times(a2, 8'd11) ^ gf_times(a3, 8'd13);
        v[111-32*c -: 8] = gf_times(a0, 8'd13) ^ gf_times(a1, 8'd9) ^
                           gf_times(a2, 8'd14) ^ gf_times(a3, 8'd11);
        v[103-32*c -: 8] = gf_times(a0, 8'd11) ^ gf_times(a1, 8'd13) ^
                           gf_times(a2, 8'd9) ^ gf_times(a3, 8'd14);
      end
      v = unshift_unsub(v);
    end
    return v ^ round_keys[0];
  endfunction

  task automatic apply_request(input key_or_block_t it);
    logic [127:0] pt;
    if (it.req_type == REQ_LOAD) begin
      // indexes past the last round key are dropped
      if (it.round_index <= ROUNDS) round_keys[it.round_index] = {it.data_hi, it.data_lo};
    end else begin
      pt = decipher_block({it.data_hi, it.data_lo});
      expected_plain.push_back(pt);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand64();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic push_req(input logic kind, input logic [3:0] idx,
                          input logic [63:0] hi, input logic [63:0] lo);
    key_or_block_t it;
    it.req_type    = kind;
    it.round_index = idx;
    it.data_hi     = hi;
    it.data_lo     = lo;
    it.drain       = drain_next;
    drain_next     = 1'b0;
    pending_reqs.push_back(it);
  endtask

  // request driver
  always @(posedge clk) begin : req_driver
    key_or_block_t nxt;
    bit            take;
    take = req_ch.valid && req_ch.ready;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (take) apply_request(in_flight);
      if (take || !req_ch.valid) begin
        if (req_gap > 0) begin
          req_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     (!pending_reqs[0].drain || expected_plain.size() == 0)) begin
          nxt = pending_reqs.pop_front();
          in_flight = nxt;
          req_ch.valid       <= 1'b1;
          req_ch.req_type    <= nxt.req_type;
          req_ch.round_index <= nxt.round_index;
          req_ch.data_hi     <= nxt.data_hi;
          req_ch.data_lo     <= nxt.data_lo;
          req_gap = pick_gap(req_calm);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and ready generator
  always @(posedge clk) begin : rsp_monitor
    plain_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_plain.size() == 0) begin
          report_mismatch($sformatf("plaintext %h_%h with no decrypt pending",
                                    rsp_ch.plain_hi, rsp_ch.plain_lo));
        end else begin
          want = expected_plain.pop_front();
          if (rsp_ch.plain_hi !== want.hi)
            report_mismatch($sformatf("plain_hi got %h expected %h", rsp_ch.plain_hi, want.hi));
          if (rsp_ch.plain_lo !== want.lo)
            report_mismatch($sformatf("plain_lo got %h expected %h", rsp_ch.plain_lo, want.lo));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 40) begin
        // long back-pressure so the block fills and stalls its input
        long_hold_done = 1'b1;
        hold_left = 400;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
        rsp_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        rsp_gap = pick_gap(rsp_calm);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin : watchdog
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0]  w [44];
    logic [31:0]  tmp;
    logic [7:0]   rcon, p, q, xb;
    logic [127:0] fips_ct, fips_pt, got;
    int           n_rand, r;
    bit           mid_drain_done;

    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_LOAD;
    req_ch.round_index = '0;
    req_ch.data_hi     = '0;
    req_ch.data_lo     = '0;
    rsp_ch.ready       = 1'b0;
    error_count = 0;
    results_seen = 0;
    req_gap = 0; req_calm = 0;
    rsp_gap = 0; rsp_calm = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    drain_next = 1'b0;
    mid_drain_done = 1'b0;

    // S-box from GF(2^8) inverse (x^254) and the affine map
    for (int x = 0; x < 256; x++) begin
      xb = 8'(x);
      p = 8'h01;
      if (x == 0) p = 8'h00;
      else for (int n = 0; n < 254; n++) p = gf_times(p, xb);
      q = p ^ {p[6:0], p[7]} ^ {p[5:0], p[7:6]} ^ {p[4:0], p[7:5]} ^ {p[3:0], p[7:4]} ^ 8'h63;
      fwd_sbox[xb] = q;
      rev_sub_lut[q] = xb;
    end

    // known-answer key schedule: key 000102..0f
    w[0] = 32'h00010203; w[1] = 32'h04050607; w[2] = 32'h08090a0b; w[3] = 32'h0c0d0e0f;
    rcon = 8'h01;
    for (int i = 4; i < 44; i++) begin
      tmp = w[i-1];
      if (i % 4 == 0) begin
        tmp = {tmp[23:0], tmp[31:24]};
        tmp = {fwd_sbox[tmp[31:24]], fwd_sbox[tmp[23:16]],
               fwd_sbox[tmp[15:8]], fwd_sbox[tmp[7:0]]} ^ {rcon, 24'h0};
        rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
      end
      w[i] = w[i-4] ^ tmp;
    end
    fips_ct = 128'h69c4e0d86a7b0430d8cdb78070b4c55a;
    fips_pt = 128'h00112233445566778899aabbccddeeff;
    for (int k = 0; k <= ROUNDS; k++) round_keys[k] = {w[4*k], w[4*k+1], w[4*k+2], w[4*k+3]};
    got = decipher_block(fips_ct);
    if (got !== fips_pt) report_mismatch($sformatf("predictor known answer %h", got));
    for (int k = 0; k <= ROUNDS; k++) round_keys[k] = '0;

    // directed part
    for (int k = 0; k <= ROUNDS; k++)
      push_req(REQ_LOAD, 4'(k), {w[4*k], w[4*k+1]}, {w[4*k+2], w[4*k+3]});
    push_req(REQ_DECRYPT, 4'd0, fips_ct[127:64], fips_ct[63:0]);
    push_req(REQ_LOAD, 4'd11, '1, '1);
    push_req(REQ_LOAD, 4'd15, rand64(), rand64());
    push_req(REQ_DECRYPT, 4'd15, fips_ct[127:64], fips_ct[63:0]);
    push_req(REQ_DECRYPT, 4'd0, '0, '0);
    push_req(REQ_DECRYPT, 4'd10, '1, '1);
    push_req(REQ_LOAD, 4'd0, '0, '0);
    push_req(REQ_LOAD, 4'd10, '1, '1);
    push_req(REQ_LOAD, 4'd12, '1, '1);
    push_req(REQ_LOAD, 4'd5, rand64(), rand64());
    push_req(REQ_DECRYPT, 4'd0, '0, '0);
    push_req(REQ_DECRYPT, 4'd0, '1, '1);
    push_req(REQ_DECRYPT, 4'd15, rand64(), rand64());

    // random part; sender drains once at the start and once midway
    drain_next = 1'b1;
    n_rand = 0;
    while (n_rand < RANDOM_ITEMS) begin
      if (!mid_drain_done && n_rand >= RANDOM_ITEMS / 2) begin
        drain_next = 1'b1;
        mid_drain_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // fresh key schedule, in either order
        if ($urandom_range(0, 1) == 0)
          for (int k = 0; k <= ROUNDS; k++) push_req(REQ_LOAD, 4'(k), rand64(), rand64());
        else
          for (int k = ROUNDS; k >= 0; k--) push_req(REQ_LOAD, 4'(k), rand64(), rand64());
        n_rand += ROUNDS + 1;
      end else if (r < 70) begin
        push_req(REQ_DECRYPT, 4'($urandom_range(0, 15)), rand64(), rand64());
        n_rand++;
      end else begin
        push_req(REQ_LOAD,
                 4'(($urandom_range(0, 99) < 85) ? $urandom_range(0, ROUNDS) :
                                                   $urandom_range(11, 15)),
                 rand64(), rand64());
        n_rand++;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_ch.valid) @(posedge clk);
    while (expected_plain.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (expected_plain.size() != 0)
      report_mismatch($sformatf("%0d plaintexts never arrived", expected_plain.size()));
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
